>>> sv/bmrp_pkg.sv
// shared types and constants for the brace message record parser
// no dependencies; used by bmrp_key_scan and brace_message_record_parser_top

package bmrp_pkg;

    // text bytes with a role in the grammar
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_HT     = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NEL    = 8'h85;
    localparam logic [7:0] CH_NBSP   = 8'hA0;

    // largest magnitude kept; valid only with a minus sign
    localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;

    // record parse phase
    typedef enum logic [5:0] {
        PH_WAIT_KEY = 6'b000001,
        PH_KEY_CMT  = 6'b000010,
        PH_KEY      = 6'b000100,
        PH_WAIT_VAL = 6'b001000,
        PH_VAL_CMT  = 6'b010000,
        PH_VALUE    = 6'b100000
    } t_phase;

    // position inside the key text
    typedef enum logic [3:0] {
        SC_LEAD   = 4'b0001,
        SC_SIGN   = 4'b0010,
        SC_DIGITS = 4'b0100,
        SC_TRAIL  = 4'b1000
    } t_scan;

    // running decimal key
    typedef struct packed {
        logic [31:0] magnitude;
        logic        negative;
        t_scan       scan;
        logic        digit_seen;
        logic        bad;
    } t_key;

    localparam t_key KEY_CLEAR = '{
        magnitude:  32'd0,
        negative:   1'b0,
        scan:       SC_LEAD,
        digit_seen: 1'b0,
        bad:        1'b0
    };

endpackage

>>> sv/bmrp_key_scan.sv
// decimal key scanner: one key byte step and the key as it would be reported
// depends on bmrp_pkg

module bmrp_key_scan (
    input  logic [7:0]    i_byte,
    input  bmrp_pkg::t_key i_state,
    output bmrp_pkg::t_key o_next,
    output logic [31:0]   o_key,
    output logic          o_key_valid
);

    logic        is_digit;
    logic        is_sign;
    logic        is_space;
    logic [3:0]  digit;
    logic [35:0] mag_wide;
    logic [35:0] mag_next;
    logic        ok;

    // byte classes
    assign is_digit = (i_byte >= bmrp_pkg::CH_ZERO) && (i_byte <= bmrp_pkg::CH_NINE);
    assign is_sign  = (i_byte == bmrp_pkg::CH_PLUS) || (i_byte == bmrp_pkg::CH_MINUS);
    assign is_space = ((i_byte >= bmrp_pkg::CH_HT) && (i_byte <= bmrp_pkg::CH_CR))
                   || (i_byte == bmrp_pkg::CH_SPACE) || (i_byte == bmrp_pkg::CH_NEL)
                   || (i_byte == bmrp_pkg::CH_NBSP);
    assign digit    = 4'(i_byte - bmrp_pkg::CH_ZERO);

    // magnitude times ten plus digit, as shift and add
    assign mag_wide = {4'd0, i_state.magnitude};
    assign mag_next = (mag_wide << 3) + (mag_wide << 1) + {32'd0, digit};

    // next key state
    always_comb begin
        o_next = i_state;
        if (is_digit) begin
            if (i_state.scan == bmrp_pkg::SC_TRAIL) begin
                o_next.bad = 1'b1;
            end else begin
                o_next.scan       = bmrp_pkg::SC_DIGITS;
                o_next.digit_seen = 1'b1;
                if (mag_next > {4'd0, bmrp_pkg::MAG_LIMIT}) begin
                    o_next.bad       = 1'b1;
                    o_next.magnitude = bmrp_pkg::MAG_LIMIT;
                end else begin
                    o_next.magnitude = mag_next[31:0];
                end
            end
        end else if (is_sign) begin
            if (i_state.scan == bmrp_pkg::SC_LEAD) begin
                o_next.negative = (i_byte == bmrp_pkg::CH_MINUS);
                o_next.scan     = bmrp_pkg::SC_SIGN;
            end else begin
                o_next.bad = 1'b1;
            end
        end else if (is_space) begin
            if (i_state.scan == bmrp_pkg::SC_SIGN) begin
                o_next.bad = 1'b1;
            end else if (i_state.scan == bmrp_pkg::SC_DIGITS) begin
                o_next.scan = bmrp_pkg::SC_TRAIL;
            end
        end else begin
            o_next.bad = 1'b1;
        end
    end

    // key validity and two's complement value
    always_comb begin
        if (!i_state.digit_seen || i_state.bad) begin
            ok = 1'b0;
        end else if (i_state.negative) begin
            ok = (i_state.magnitude <= bmrp_pkg::MAG_LIMIT);
        end else begin
            ok = (i_state.magnitude < bmrp_pkg::MAG_LIMIT);
        end
    end

    assign o_key_valid = ok;
    assign o_key       = !ok ? 32'd0
                       : (i_state.negative ? (32'd0 - i_state.magnitude) : i_state.magnitude);

endmodule

>>> sv/brace_message_record_parser_top.sv
// top level of the brace message record parser: input register, phase machine, result register
// depends on bmrp_pkg and bmrp_key_scan

// Takes one text byte per transfer and returns one result for each value byte and one
// record-end result for each closing brace of a value; other bytes give no result. A byte
// is taken into an input register and then advances through the phase machine and key
// scanner into the result register, from which its result is offered. One byte can be taken
// every cycle; the only stall is when a byte that gives a result meets a full result
// register that is not being drained.
// Comments start with two slashes while a key or value is awaited and run to the newline.

module brace_message_record_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_char_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_record_end,
    output logic [7:0]  o_value_byte,
    output logic [31:0] o_key,
    output logic        o_key_valid
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    bmrp_pkg::t_phase r_phase;
    bmrp_pkg::t_phase n_phase;
    logic [7:0]       r_prior;
    bmrp_pkg::t_key   r_key;
    bmrp_pkg::t_key   n_key;
    bmrp_pkg::t_key   key_fed;
    logic [31:0]      key_out;
    logic             key_out_valid;
    logic             r_out_valid;
    logic             r_record_end;
    logic [7:0]       r_value_byte;
    logic [31:0]      r_key_out;
    logic             r_key_valid;
    logic             slash2;
    logic             emits;
    logic             out_free;
    logic             advance;

    // key scanner on the registered byte
    bmrp_key_scan u_key_scan (
        .i_byte      (r_in_byte),
        .i_state     (r_key),
        .o_next      (key_fed),
        .o_key       (key_out),
        .o_key_valid (key_out_valid)
    );

    // flow control
    assign emits      = (r_phase == bmrp_pkg::PH_VALUE);
    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && (!emits || out_free);
    assign o_in_ready = !r_in_valid || advance;
    assign slash2     = (r_in_byte == bmrp_pkg::CH_SLASH) && (r_prior == bmrp_pkg::CH_SLASH);

    // phase and key next state
    always_comb begin
        n_phase = r_phase;
        n_key   = r_key;
        unique case (r_phase)
            bmrp_pkg::PH_KEY_CMT: begin
                if (r_in_byte == bmrp_pkg::CH_NL) begin
                    n_phase = bmrp_pkg::PH_WAIT_KEY;
                end
            end
            bmrp_pkg::PH_KEY: begin
                if (r_in_byte == bmrp_pkg::CH_RBRACE) begin
                    n_phase = bmrp_pkg::PH_WAIT_VAL;
                end else begin
                    n_key = key_fed;
                end
            end
            bmrp_pkg::PH_WAIT_VAL: begin
                if (r_in_byte == bmrp_pkg::CH_LBRACE) begin
                    n_phase = bmrp_pkg::PH_VALUE;
                end else if (slash2) begin
                    n_phase = bmrp_pkg::PH_VAL_CMT;
                end
            end
            bmrp_pkg::PH_VAL_CMT: begin
                if (r_in_byte == bmrp_pkg::CH_NL) begin
                    n_phase = bmrp_pkg::PH_WAIT_VAL;
                end
            end
            bmrp_pkg::PH_VALUE: begin
                if (r_in_byte == bmrp_pkg::CH_RBRACE) begin
                    n_key   = bmrp_pkg::KEY_CLEAR;
                    n_phase = bmrp_pkg::PH_WAIT_KEY;
                end
            end
            default: begin
                if (r_in_byte == bmrp_pkg::CH_LBRACE) begin
                    n_phase = bmrp_pkg::PH_KEY;
                end else if (slash2) begin
                    n_phase = bmrp_pkg::PH_KEY_CMT;
                end else begin
                    n_phase = bmrp_pkg::PH_WAIT_KEY;
                end
            end
        endcase
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_char_byte;
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= bmrp_pkg::PH_WAIT_KEY;
            r_prior <= 8'd0;
            r_key   <= bmrp_pkg::KEY_CLEAR;
        end else if (advance) begin
            r_phase <= n_phase;
            r_prior <= r_in_byte;
            r_key   <= n_key;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emits) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emits) begin
            r_record_end <= (r_in_byte == bmrp_pkg::CH_RBRACE);
            r_value_byte <= (r_in_byte == bmrp_pkg::CH_RBRACE) ? 8'd0 : r_in_byte;
            r_key_out    <= key_out;
            r_key_valid  <= key_out_valid;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_record_end = r_record_end;
    assign o_value_byte = r_value_byte;
    assign o_key        = r_key_out;
    assign o_key_valid  = r_key_valid;

endmodule

>>> test/testbench.sv
// self-checking testbench for brace_message_record_parser_top: directed, backpressure and random text
// depends on bmrp_pkg and the parser rtl; predicts every record result from its own parse model

`timescale 1ns / 100ps

module testbench;

    localparam int CLK_HALF   = 2;
    localparam int STUCK_MAX  = 4000;
    localparam int HOLD_LONG  = 300;

    // one predicted record result
    typedef struct {
        logic        record_end;
        logic [7:0]  value_byte;
        logic [31:0] key;
        logic        key_valid;
    } t_rec_item;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_char_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_record_end;
    logic [7:0]  o_value_byte;
    logic [31:0] o_key;
    logic        o_key_valid;

    // parse model state
    bmrp_pkg::t_phase parse_state;
    logic [7:0]       last_byte;
    bmrp_pkg::t_key   key_acc;

    t_rec_item   pending_records [$];
    logic [7:0]  text_q [$];

    int          fail_count    = 0;
    int          sent_count    = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_len      = 0;
    int          stuck_cycles  = 0;

    brace_message_record_parser_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_char_byte  (i_char_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_record_end (o_record_end),
        .o_value_byte (o_value_byte),
        .o_key        (o_key),
        .o_key_valid  (o_key_valid)
    );

    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    // ---------------------------------------------------------------- parse model

    function automatic logic is_blank(input logic [7:0] c);
        return (c >= bmrp_pkg::CH_HT && c <= bmrp_pkg::CH_CR) || c == bmrp_pkg::CH_SPACE
            || c == bmrp_pkg::CH_NEL || c == bmrp_pkg::CH_NBSP;
    endfunction

    // advance the running decimal key by one key byte
    task automatic scan_key_byte(input logic [7:0] c);
        logic [63:0] m;
        if (c >= bmrp_pkg::CH_ZERO && c <= bmrp_pkg::CH_NINE) begin
            if (key_acc.scan == bmrp_pkg::SC_TRAIL) begin
                key_acc.bad = 1'b1;
            end else begin
                key_acc.scan       = bmrp_pkg::SC_DIGITS;
                key_acc.digit_seen = 1'b1;
                m = {32'd0, key_acc.magnitude} * 64'd10 + {56'd0, c - bmrp_pkg::CH_ZERO};
                if (m > {32'd0, bmrp_pkg::MAG_LIMIT}) begin
                    key_acc.bad = 1'b1;
                    m = {32'd0, bmrp_pkg::MAG_LIMIT};
                end
                key_acc.magnitude = m[31:0];
            end
        end else if (c == bmrp_pkg::CH_PLUS || c == bmrp_pkg::CH_MINUS) begin
            if (key_acc.scan == bmrp_pkg::SC_LEAD) begin
                key_acc.negative = (c == bmrp_pkg::CH_MINUS);
                key_acc.scan     = bmrp_pkg::SC_SIGN;
            end else begin
                key_acc.bad = 1'b1;
            end
        end else if (is_blank(c)) begin
            if (key_acc.scan == bmrp_pkg::SC_SIGN)
                key_acc.bad = 1'b1;
            else if (key_acc.scan == bmrp_pkg::SC_DIGITS)
                key_acc.scan = bmrp_pkg::SC_TRAIL;
        end else begin
            key_acc.bad = 1'b1;
        end
    endtask

    // queue the result of a value byte or a record end with the current key
    task automatic push_record(input logic rec_end, input logic [7:0] vb);
        t_rec_item r;
        logic      ok;
        ok = key_acc.digit_seen && !key_acc.bad &&
             (key_acc.negative ? (key_acc.magnitude <= bmrp_pkg::MAG_LIMIT)
                               : (key_acc.magnitude < bmrp_pkg::MAG_LIMIT));
        r.record_end = rec_end;
        r.value_byte = vb;
        r.key_valid  = ok;
        r.key        = !ok ? 32'd0 :
                       key_acc.negative ? (32'd0 - key_acc.magnitude) : key_acc.magnitude;
        pending_records.push_back(r);
    endtask

    // one accepted text byte through the phase machine
    task automatic parse_byte(input logic [7:0] c);
        logic slash_pair;
        slash_pair = (c == bmrp_pkg::CH_SLASH) && (last_byte == bmrp_pkg::CH_SLASH);
        case (parse_state)
            bmrp_pkg::PH_KEY_CMT: begin
                if (c == bmrp_pkg::CH_NL) parse_state = bmrp_pkg::PH_WAIT_KEY;
            end
            bmrp_pkg::PH_KEY: begin
                if (c == bmrp_pkg::CH_RBRACE) parse_state = bmrp_pkg::PH_WAIT_VAL;
                else scan_key_byte(c);
            end
            bmrp_pkg::PH_WAIT_VAL: begin
                if (c == bmrp_pkg::CH_LBRACE) parse_state = bmrp_pkg::PH_VALUE;
                else if (slash_pair) parse_state = bmrp_pkg::PH_VAL_CMT;
            end
            bmrp_pkg::PH_VAL_CMT: begin
                if (c == bmrp_pkg::CH_NL) parse_state = bmrp_pkg::PH_WAIT_VAL;
            end
            bmrp_pkg::PH_VALUE: begin
                if (c == bmrp_pkg::CH_RBRACE) begin
                    push_record(1'b1, 8'd0);
                    key_acc     = bmrp_pkg::KEY_CLEAR;
                    parse_state = bmrp_pkg::PH_WAIT_KEY;
                end else begin
                    push_record(1'b0, c);
                end
            end
            default: begin
                if (c == bmrp_pkg::CH_LBRACE) parse_state = bmrp_pkg::PH_KEY;
                else if (slash_pair) parse_state = bmrp_pkg::PH_KEY_CMT;
                else parse_state = bmrp_pkg::PH_WAIT_KEY;
            end
        endcase
        last_byte = c;
    endtask

    // ---------------------------------------------------------------- input side

    // offer one byte, hold it until the transfer, then update the model
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_char_byte <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        parse_byte(b);
        sent_count++;
    endtask

    task automatic flush_text();
        while (text_q.size() > 0) send_byte(text_q.pop_front());
    endtask

    // drop valid and wait until every predicted result has come out
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_records.size() > 0) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------- text generation

    function automatic logic [7:0] pick_space();
        case ($urandom_range(7))
            0: return 8'h09;
            1: return 8'h0A;
            2: return 8'h0B;
            3: return 8'h0C;
            4: return 8'h0D;
            5: return bmrp_pkg::CH_SPACE;
            6: return bmrp_pkg::CH_NEL;
            default: return bmrp_pkg::CH_NBSP;
        endcase
    endfunction

    function automatic logic [7:0] rand_other(input logic [7:0] skip);
        logic [7:0] r;
        r = 8'($urandom_range(255));
        while (r == skip) r = 8'($urandom_range(255));
        return r;
    endfunction

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endtask

    task automatic push_digits(input int n);
        repeat (n) text_q.push_back(bmrp_pkg::CH_ZERO + 8'($urandom_range(9)));
    endtask

    // whitespace, a comment or a lone slash while a key or a value is awaited
    task automatic add_filler();
        case ($urandom_range(3))
            1: repeat ($urandom_range(1, 3)) text_q.push_back(pick_space());
            2: begin
                push_str("//");
                repeat ($urandom_range(6)) text_q.push_back(rand_other(bmrp_pkg::CH_NL));
                text_q.push_back(bmrp_pkg::CH_NL);
            end
            3: begin
                text_q.push_back(bmrp_pkg::CH_SLASH);
                text_q.push_back(pick_space());
            end
            default: ;
        endcase
    endtask

    // a braced key, some well formed, the rest malformed in assorted ways
    task automatic add_key();
        int kind;
        int start;
        text_q.push_back(bmrp_pkg::CH_LBRACE);
        start = text_q.size();
        kind  = $urandom_range(9);
        case (kind)
            4: begin
                case ($urandom_range(7))
                    0: push_str("2147483647");
                    1: push_str("-2147483648");
                    2: push_str("2147483648");
                    3: push_str("+2147483647");
                    4: push_str("-2147483649");
                    5: push_str("+2147483648");
                    6: push_str("-0");
                    default: push_str("4294967296");
                endcase
            end
            5: push_digits($urandom_range(11, 13));
            7: begin
                // digit after trailing blank, sign after digits, blank after sign, double sign
                case ($urandom_range(3))
                    0: begin
                        push_digits(2);
                        text_q.push_back(pick_space());
                        push_digits(1);
                    end
                    1: push_str("1-2");
                    2: begin
                        text_q.push_back(bmrp_pkg::CH_MINUS);
                        text_q.push_back(pick_space());
                        push_digits(1);
                    end
                    default: push_str("+-1");
                endcase
            end
            8: begin
                case ($urandom_range(3))
                    1: text_q.push_back(bmrp_pkg::CH_PLUS);
                    2: text_q.push_back(bmrp_pkg::CH_MINUS);
                    3: repeat ($urandom_range(1, 2)) text_q.push_back(pick_space());
                    default: ;
                endcase
            end
            9: repeat ($urandom_range(1, 5)) text_q.push_back(rand_other(bmrp_pkg::CH_RBRACE));
            default: begin
                repeat ($urandom_range(2)) text_q.push_back(pick_space());
                case ($urandom_range(2))
                    1: text_q.push_back(bmrp_pkg::CH_PLUS);
                    2: text_q.push_back(bmrp_pkg::CH_MINUS);
                    default: ;
                endcase
                push_digits($urandom_range(1, 10));
                repeat ($urandom_range(2)) text_q.push_back(pick_space());
                // one stray byte somewhere in an otherwise good key
                if (kind == 6)
                    text_q.insert($urandom_range(start, text_q.size()),
                                  rand_other(bmrp_pkg::CH_RBRACE));
            end
        endcase
        text_q.push_back(bmrp_pkg::CH_RBRACE);
    endtask

    task automatic add_value(input int max_len);
        text_q.push_back(bmrp_pkg::CH_LBRACE);
        repeat ($urandom_range(max_len)) text_q.push_back(rand_other(bmrp_pkg::CH_RBRACE));
        text_q.push_back(bmrp_pkg::CH_RBRACE);
    endtask

    // ---------------------------------------------------------------- tests

    // extreme key, extreme value bytes, a comment, an empty key and an empty value
    task automatic test_directed();
        push_str("{-2147483648}{");
        text_q.push_back(8'h00);
        text_q.push_back(8'hFF);
        push_str("}//x");
        text_q.push_back(bmrp_pkg::CH_NL);
        push_str("{}{}");
        flush_text();
    endtask

    // receiver stalls for a long stretch while a long value keeps coming
    task automatic test_backpressure();
        hold_len = HOLD_LONG;
        push_str("{7}");
        add_value(60);
        push_str("{-12}{abcdefghijklmnopqrstuvwxyz0123456789}");
        flush_text();
        wait_drained();
    endtask

    // mostly well-formed records with random content, plus noise and broken records
    task automatic test_random(input int s_pct, input int r_pct, input int n_items);
        int stop_at;
        int pick;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        stop_at = sent_count + n_items;
        while (sent_count < stop_at) begin
            add_filler();
            pick = $urandom_range(99);
            if (pick < 85) begin
                add_key();
                add_filler();
                add_value(10);
            end else if (pick < 92) begin
                repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(255)));
            end else begin
                add_key();
                if (pick < 96) void'(text_q.pop_back());
            end
            flush_text();
        end
    endtask

    // ---------------------------------------------------------------- output side

    // receiver ready, with random idling and an occasional long hold-off
    initial begin : receiver
        int n;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_len > 0) begin
                n = hold_len;
                hold_len = 0;
                repeat (n) begin
                    i_out_ready <= 1'b0;
                    @(negedge i_clk);
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_rec_item r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_records.size() == 0) begin
                $display("%0t: unexpected result expected none actual end=%b byte=%h key=%h ok=%b",
                         $time, o_record_end, o_value_byte, o_key, o_key_valid);
                fail_count++;
            end else begin
                r = pending_records.pop_front();
                check_field("record_end", 32'(r.record_end), 32'(o_record_end));
                check_field("value_byte", 32'(r.value_byte), 32'(o_value_byte));
                check_field("key",        r.key,             o_key);
                check_field("key_valid",  32'(r.key_valid),  32'(o_key_valid));
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_MAX) begin
            $display("brace_message_record_parser_top: mismatch");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_char_byte = 8'd0;
        parse_state = bmrp_pkg::PH_WAIT_KEY;
        last_byte   = 8'd0;
        key_acc     = bmrp_pkg::KEY_CLEAR;
        send_idle_pct = 10;
        recv_idle_pct = 55;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_backpressure();
        test_random(10, 55, 520);
        wait_drained();
        test_random(55, 10, 520);
        wait_drained();
        test_random(0, 0, 530);
        wait_drained();

        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("brace_message_record_parser_top: match");
        else
            $display("brace_message_record_parser_top: mismatch");
        $finish;
    end

endmodule
